// File: rtl/iso2sj_pkg.sv
// Shared types for the ISO-2022-JP to Shift_JIS stream converter.
// Holds the command and status bundles that join the controller and the datapath.
// No dependencies.
package iso2sj_pkg;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
        logic finish;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic queue_pend;
        logic esc_held;
        logic last;
        logic out_empty;
        logic out_last;
    } t_sts;

endpackage

// File: rtl/iso2sj_in_if.sv
// Input channel of the converter: one ISO-2022-JP byte per beat.
// Valid/ready handshake; no dependencies.
interface iso2sj_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_last;

    modport source (output valid, output in_byte, output stream_last, input ready);
    modport sink   (input valid, input in_byte, input stream_last, output ready);
endinterface

// File: rtl/iso2sj_out_if.sv
// Output channel of the converter: one Shift_JIS byte per beat.
// Valid/ready handshake; no dependencies.
interface iso2sj_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic [3:0] mode_now;

    modport source (output valid, output out_byte, output run_last, output mode_now,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input mode_now,
                    output ready);
endinterface

// File: rtl/iso2sj_dp.sv
// Datapath of the converter: byte window, escape matcher, mode and lead state,
// byte conversion and the result buffer. Driven by iso2sj_ctrl; uses iso2sj_pkg.
module iso2sj_dp
    import iso2sj_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_last,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic [3:0] o_mode_now
);

    localparam logic [7:0] ESC         = 8'h1B;
    localparam logic [3:0] MODE_DEFAULT = 4'd0;
    localparam logic [3:0] MODE_ROMAN   = 4'd2;
    localparam logic [3:0] MODE_KANA    = 4'd3;
    localparam logic [3:0] MODE_KJ_LO   = 4'd4;
    localparam logic [3:0] MODE_KJ_HI   = 4'd6;
    localparam int         NUM_SEQ      = 10;
    localparam int         WIN          = 6;
    localparam int         OUT_DEPTH    = 8;

    localparam logic [7:0] SEQ_BYTES [NUM_SEQ][WIN] = '{
        '{8'h1B, 8'h28, 8'h42, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h28, 8'h4A, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h28, 8'h49, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h40, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h42, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h26, 8'h40, 8'h1B, 8'h24, 8'h42},
        '{8'h1B, 8'h24, 8'h28, 8'h44, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h28, 8'h4F, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h28, 8'h51, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h28, 8'h50, 8'h00, 8'h00}
    };
    localparam logic [2:0] SEQ_LEN [NUM_SEQ] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4
    };

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_PREFIX,
        CLS_COMPLETE
    } t_cls_kind;

    typedef struct packed {
        t_cls_kind  kind;
        logic [3:0] mode;
    } t_cls;

    typedef struct packed {
        logic [7:0] lead;
        logic       lead_vld;
        logic [1:0] n_emit;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_ord;

    function automatic t_cls classify(input logic [WIN-1:0][7:0] w, input logic [2:0] n);
        t_cls res;
        logic found;
        logic match;
        res.kind = CLS_NONE;
        res.mode = MODE_DEFAULT;
        found    = 1'b0;
        for (int s = 0; s < NUM_SEQ; s++) begin
            match = (n <= SEQ_LEN[s]);
            for (int k = 0; k < WIN; k++) begin
                if ((3'(k) < n) && (w[k] != SEQ_BYTES[s][k])) begin
                    match = 1'b0;
                end
            end
            if (match && !found) begin
                found    = 1'b1;
                res.kind = (n == SEQ_LEN[s]) ? CLS_COMPLETE : CLS_PREFIX;
                res.mode = 4'(s + 1);
            end
        end
        return res;
    endfunction

    function automatic logic [15:0] kanji(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] c1;
        logic [8:0] c2;
        if (a[0]) begin
            c1 = (({1'b0, a} + 9'd1) >> 1) + 9'h070;
            c2 = {1'b0, b} + 9'h01F;
        end else begin
            c1 = ({1'b0, a} >> 1) + 9'h070;
            c2 = {1'b0, b} + 9'h07D;
        end
        if (c1 >= 9'h0A0) begin
            c1 = c1 + 9'h040;
        end
        if (c2 >= 9'h07F) begin
            c2 = c2 + 9'd1;
        end
        return {c1[7:0], c2[7:0]};
    endfunction

    function automatic t_ord ordinary(input logic [7:0] b, input logic [3:0] mode,
                                      input logic [7:0] lead, input logic lead_vld);
        t_ord res;
        logic pair;
        pair         = (b >= 8'h21) && (b <= 8'h7E);
        res.lead     = lead;
        res.lead_vld = 1'b0;
        res.n_emit   = 2'd0;
        res.b0       = b;
        res.b1       = 8'h00;
        if (lead_vld && pair) begin
            if ((mode >= MODE_KJ_LO) && (mode <= MODE_KJ_HI)) begin
                {res.b0, res.b1} = kanji(lead, b);
                res.n_emit       = 2'd2;
            end
        end else if (mode <= MODE_ROMAN) begin
            if (b <= 8'h7F) begin
                res.n_emit = 2'd1;
            end
        end else if (mode == MODE_KANA) begin
            if ((b >= 8'h21) && (b <= 8'h5F)) begin
                res.b0     = b + 8'h80;
                res.n_emit = 2'd1;
            end
        end else if (pair) begin
            res.lead     = b;
            res.lead_vld = 1'b1;
        end
        return res;
    endfunction

    logic [WIN-1:0][7:0]       r_win, n_win;
    logic [2:0]                r_cnt, n_cnt;
    logic [2:0]                r_esc_len, n_esc_len;
    logic [3:0]                r_mode, n_mode;
    logic [7:0]                r_lead, n_lead;
    logic                      r_lead_vld, n_lead_vld;
    logic                      r_last, n_last;
    logic [OUT_DEPTH-1:0][7:0] r_obuf, n_obuf;
    logic [3:0]                r_ocnt, n_ocnt;
    logic [2:0]                r_oidx, n_oidx;
    logic [3:0]                r_mode_out, n_mode_out;

    t_cls       cls;
    t_ord       ord;
    logic       do_ord;
    logic [2:0] shift;
    logic [3:0] ocnt_sum;

    always_comb begin
        n_win      = r_win;
        n_cnt      = r_cnt;
        n_esc_len  = r_esc_len;
        n_mode     = r_mode;
        n_lead     = r_lead;
        n_lead_vld = r_lead_vld;
        n_last     = r_last;
        n_obuf     = r_obuf;
        n_ocnt     = r_ocnt;
        n_oidx     = r_oidx;
        n_mode_out = r_mode_out;
        do_ord     = 1'b0;
        shift      = 3'd0;
        ocnt_sum   = 4'd0;
        cls        = classify(r_win, r_esc_len + 3'd1);
        ord        = ordinary(r_win[0], r_mode, r_lead, r_lead_vld);

        if (i_cmd.load) begin
            n_win[r_cnt] = i_in_byte;
            n_cnt        = r_cnt + 3'd1;
            n_last       = i_stream_last;
            n_ocnt       = 4'd0;
            n_oidx       = 3'd0;
        end

        if (i_cmd.step) begin
            if ((r_esc_len == 3'd0) && (r_win[0] != ESC)) begin
                do_ord = 1'b1;
                shift  = 3'd1;
            end else begin
                if (r_esc_len == 3'd0) begin
                    n_lead_vld = 1'b0;
                end
                unique case (cls.kind)
                    CLS_COMPLETE: begin
                        n_mode    = cls.mode;
                        shift     = r_esc_len + 3'd1;
                        n_esc_len = 3'd0;
                    end
                    CLS_PREFIX: begin
                        n_esc_len = r_esc_len + 3'd1;
                    end
                    default: begin
                        do_ord    = 1'b1;
                        shift     = 3'd1;
                        n_esc_len = 3'd0;
                    end
                endcase
            end
        end

        if (i_cmd.flush) begin
            do_ord    = 1'b1;
            shift     = 3'd1;
            n_esc_len = r_esc_len - 3'd1;
        end

        if (do_ord) begin
            n_lead     = ord.lead;
            n_lead_vld = ord.lead_vld;
            for (int i = 0; i < OUT_DEPTH; i++) begin
                if ((ord.n_emit != 2'd0) && (r_ocnt == 4'(i))) begin
                    n_obuf[i] = ord.b0;
                end
                if ((ord.n_emit == 2'd2) && ((r_ocnt + 4'd1) == 4'(i))) begin
                    n_obuf[i] = ord.b1;
                end
            end
            ocnt_sum = r_ocnt + {2'b00, ord.n_emit};
            n_ocnt   = (ocnt_sum > 4'(OUT_DEPTH)) ? 4'(OUT_DEPTH) : ocnt_sum;
        end

        if (shift != 3'd0) begin
            n_win = r_win >> {shift, 3'b000};
            n_cnt = r_cnt - shift;
        end

        if (i_cmd.finish) begin
            n_mode_out = r_mode;
            if (r_last) begin
                n_mode     = MODE_DEFAULT;
                n_lead     = 8'h00;
                n_lead_vld = 1'b0;
                n_esc_len  = 3'd0;
                n_cnt      = 3'd0;
                n_last     = 1'b0;
            end
        end

        if (i_cmd.advance) begin
            n_oidx = r_oidx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 3'd0;
            r_esc_len  <= 3'd0;
            r_mode     <= MODE_DEFAULT;
            r_lead     <= 8'h00;
            r_lead_vld <= 1'b0;
            r_last     <= 1'b0;
            r_ocnt     <= 4'd0;
            r_oidx     <= 3'd0;
        end else begin
            r_cnt      <= n_cnt;
            r_esc_len  <= n_esc_len;
            r_mode     <= n_mode;
            r_lead     <= n_lead;
            r_lead_vld <= n_lead_vld;
            r_last     <= n_last;
            r_ocnt     <= n_ocnt;
            r_oidx     <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_obuf     <= n_obuf;
        r_mode_out <= n_mode_out;
    end

    assign o_sts.queue_pend = (r_cnt != r_esc_len);
    assign o_sts.esc_held   = (r_esc_len != 3'd0);
    assign o_sts.last       = r_last;
    assign o_sts.out_empty  = (r_ocnt == 4'd0);
    assign o_sts.out_last   = (({1'b0, r_oidx} + 4'd1) == r_ocnt);

    assign o_out_byte = r_obuf[r_oidx];
    assign o_run_last = o_sts.out_last;
    assign o_mode_now = r_mode_out;

endmodule

// File: rtl/iso2sj_ctrl.sv
// Controller of the converter: sequences accept, scan, flush, finish and drain.
// Drives iso2sj_dp through t_cmd and reads t_sts; uses iso2sj_pkg.
module iso2sj_ctrl
    import iso2sj_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.queue_pend) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.last && i_sts.esc_held) begin
                    o_cmd.flush = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = i_sts.out_empty ? S_IDLE : S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DRAIN);

endmodule

// File: rtl/iso2022jp_to_shift_jis_stream_core.sv
// ISO-2022-JP to Shift_JIS stream converter, top level. Takes one input byte per
// beat and returns zero to eight Shift_JIS bytes for it, the last one flagged with
// run_last and all of them carrying the mode reached after that input byte. Bytes
// are handled one at a time: the byte is accepted, the matcher takes a step for each
// queued byte (held escape bytes that no longer match are rescanned), a final byte
// flushes each held escape byte, the input is closed, then the results are drained
// one per output beat. Stream end resets the mode to default.
// Uses iso2sj_pkg, iso2sj_in_if, iso2sj_out_if, iso2sj_ctrl and iso2sj_dp.
module iso2022jp_to_shift_jis_stream_core
    import iso2sj_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    iso2sj_in_if.sink    i_in,
    iso2sj_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    iso2sj_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    iso2sj_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_byte     (i_in.in_byte),
        .i_stream_last (i_in.stream_last),
        .o_out_byte    (o_out.out_byte),
        .o_run_last    (o_out.run_last),
        .o_mode_now    (o_out.mode_now)
    );

endmodule

// File: tb/tb_iso2022jp_to_shift_jis_stream_core.sv
`timescale 1ns / 1ps
// Testbench for iso2022jp_to_shift_jis_stream_core: drives ISO-2022-JP byte streams and checks
// every Shift_JIS beat against an in-bench converter model with random source/sink idling.
// Depends on iso2sj_pkg, iso2sj_in_if, iso2sj_out_if and the converter RTL.
module tb_iso2022jp_to_shift_jis_stream_core;
    import iso2sj_pkg::*;

    typedef enum logic [3:0] {
        MODE_DEFAULT      = 4'd0,
        MODE_ASCII        = 4'd1,
        MODE_ROMAN        = 4'd2,
        MODE_KANA         = 4'd3,
        MODE_KANJI_1978   = 4'd4,
        MODE_KANJI_1983   = 4'd5,
        MODE_KANJI_1990   = 4'd6,
        MODE_SUPPL_0212   = 4'd7,
        MODE_X0213_P1     = 4'd8,
        MODE_X0213_P1_04  = 4'd9,
        MODE_X0213_P2     = 4'd10
    } t_jis_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       tail;
        logic [3:0] mode;
    } t_sj_beat;

    localparam logic [7:0] ESC_BYTE    = 8'h1B;
    localparam logic [7:0] PAIR_LO     = 8'h21;
    localparam logic [7:0] PAIR_HI     = 8'h7E;
    localparam logic [7:0] KANA_HI     = 8'h5F;
    localparam logic [7:0] KANA_SHIFT  = 8'h80;
    localparam logic [7:0] ASCII_HI    = 8'h7F;
    localparam int         SJ_ROW_BASE = 'h70;
    localparam int         ODD_TRAIL   = 'h1F;
    localparam int         EVEN_TRAIL  = 'h7D;
    localparam int         ROW_GAP_AT  = 'hA0;
    localparam int         ROW_GAP     = 'h40;
    localparam int         DEL_SKIP_AT = 'h7F;
    localparam int         MAX_STEP_OUT = 8;
    localparam int         ESC_DEPTH   = 5;
    localparam int         NUM_SEQ     = 10;

    localparam logic [7:0] ESC_SEQ [NUM_SEQ][6] = '{
        '{8'h1B, 8'h28, 8'h42, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h28, 8'h4A, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h28, 8'h49, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h40, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h42, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h26, 8'h40, 8'h1B, 8'h24, 8'h42},
        '{8'h1B, 8'h24, 8'h28, 8'h44, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h28, 8'h4F, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h28, 8'h51, 8'h00, 8'h00},
        '{8'h1B, 8'h24, 8'h28, 8'h50, 8'h00, 8'h00}
    };
    localparam int ESC_LEN [NUM_SEQ] = '{3, 3, 3, 3, 3, 6, 4, 4, 4, 4};
    localparam t_jis_mode ESC_MODE [NUM_SEQ] = '{
        MODE_ASCII, MODE_ROMAN, MODE_KANA, MODE_KANJI_1978, MODE_KANJI_1983,
        MODE_KANJI_1990, MODE_SUPPL_0212, MODE_X0213_P1, MODE_X0213_P1_04, MODE_X0213_P2
    };

    logic i_clk;
    logic i_rst_n;

    iso2sj_in_if  in_if();
    iso2sj_out_if out_if();

    iso2022jp_to_shift_jis_stream_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_jis_mode   cs_mode;
    logic [7:0]  kanji_lead;
    logic        lead_held;
    logic [7:0]  esc_hold [ESC_DEPTH];
    int unsigned esc_count;
    logic [7:0]  step_out [$];
    t_sj_beat    shift_jis_q [$];

    int src_idle_pct;
    int snk_stall_pct;
    int sent_bytes;
    int mismatch_count;

    function automatic void jis_reset();
        cs_mode    = MODE_DEFAULT;
        kanji_lead = 8'h00;
        lead_held  = 1'b0;
        esc_count  = 0;
    endfunction

    function automatic void jis_emit(input logic [7:0] b);
        if (step_out.size() < MAX_STEP_OUT)
            step_out.push_back(b);
    endfunction

    function automatic void jis_kanji(input logic [7:0] a, input logic [7:0] b);
        int c1;
        int c2;
        if (a[0]) begin
            c1 = (int'(a) + 1) / 2 + SJ_ROW_BASE;
            c2 = int'(b) + ODD_TRAIL;
        end else begin
            c1 = int'(a) / 2 + SJ_ROW_BASE;
            c2 = int'(b) + EVEN_TRAIL;
        end
        if (c1 >= ROW_GAP_AT) c1 += ROW_GAP;
        if (c2 >= DEL_SKIP_AT) c2 += 1;
        jis_emit(8'(c1));
        jis_emit(8'(c2));
    endfunction

    function automatic void jis_plain(input logic [7:0] b);
        logic pair_ok;
        pair_ok = (b >= PAIR_LO) && (b <= PAIR_HI);
        if (lead_held) begin
            lead_held = 1'b0;
            if (pair_ok) begin
                if (cs_mode >= MODE_KANJI_1978 && cs_mode <= MODE_KANJI_1990)
                    jis_kanji(kanji_lead, b);
                return;
            end
        end
        if (cs_mode <= MODE_ROMAN) begin
            if (b <= ASCII_HI) jis_emit(b);
        end else if (cs_mode == MODE_KANA) begin
            if (b >= PAIR_LO && b <= KANA_HI) jis_emit(b + KANA_SHIFT);
        end else if (pair_ok) begin
            kanji_lead = b;
            lead_held  = 1'b1;
        end
    endfunction

    // -1: no sequence fits, 0: proper prefix, >0: complete, mode code
    function automatic int jis_match(input logic [7:0] seq [6], input int unsigned n);
        int k;
        for (int s = 0; s < NUM_SEQ; s++) begin
            if (n > ESC_LEN[s]) continue;
            k = 0;
            while (k < n && seq[k] == ESC_SEQ[s][k]) k++;
            if (k == n) return (n == ESC_LEN[s]) ? int'(ESC_MODE[s]) : 0;
        end
        return -1;
    endfunction

    // replayed bytes go to the front so they are rescanned before anything else
    function automatic void jis_feed(input logic [7:0] first);
        logic [7:0]  pend [$];
        logic [7:0]  seq [6];
        logic [7:0]  b;
        int unsigned n;
        int          r;
        pend.push_back(first);
        while (pend.size() != 0) begin
            b = pend.pop_front();
            n = esc_count;
            if (n == 0 && b != ESC_BYTE) begin
                jis_plain(b);
                continue;
            end
            if (n == 0) lead_held = 1'b0;
            for (int k = 0; k < n; k++) seq[k] = esc_hold[k];
            seq[n] = b;
            n++;
            r = jis_match(seq, n);
            if (r > 0) begin
                cs_mode   = t_jis_mode'(r);
                esc_count = 0;
            end else if (r == 0 && n <= ESC_DEPTH) begin
                for (int k = 0; k < n; k++) esc_hold[k] = seq[k];
                esc_count = n;
            end else begin
                esc_count = 0;
                jis_plain(seq[0]);
                for (int k = int'(n) - 1; k >= 1; k--) pend.push_front(seq[k]);
            end
        end
    endfunction

    function automatic void predict_shift_jis(input logic [7:0] b, input logic last);
        logic [7:0]  held [ESC_DEPTH];
        int unsigned n;
        t_sj_beat    beat;
        step_out.delete();
        jis_feed(b);
        if (last) begin
            n = esc_count;
            for (int k = 0; k < n; k++) held[k] = esc_hold[k];
            esc_count = 0;
            for (int k = 0; k < n; k++) jis_plain(held[k]);
            lead_held = 1'b0;
        end
        for (int k = 0; k < step_out.size(); k++) begin
            beat.ch   = step_out[k];
            beat.tail = (k == step_out.size() - 1);
            beat.mode = cs_mode;
            shift_jis_q.push_back(beat);
        end
        if (last) jis_reset();
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk)
        out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    always @(posedge i_clk) begin : monitor
        t_sj_beat want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (shift_jis_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t unexpected beat: out_byte %h run_last %b mode_now %0d",
                                 $realtime, out_if.out_byte, out_if.run_last, out_if.mode_now);
                    mismatch_count++;
                end else begin
                    want = shift_jis_q.pop_front();
                    if (out_if.out_byte !== want.ch || out_if.run_last !== want.tail ||
                        out_if.mode_now !== want.mode) begin
                        if (mismatch_count < 10)
                            $display("%0t mismatch: out_byte %h/%h run_last %b/%b mode_now %0d/%0d",
                                     $realtime, want.ch, out_if.out_byte, want.tail,
                                     out_if.run_last, want.mode, out_if.mode_now);
                        mismatch_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready)
                predict_shift_jis(in_if.in_byte, in_if.stream_last);
        end
    end

    // call just after a falling edge; returns just after the falling edge past the beat
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       = 1'b1;
        in_if.in_byte     = b;
        in_if.stream_last = last;
        do @(posedge i_clk); while (!in_if.ready);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input logic [7:0] seq [$], input logic end_stream);
        for (int k = 0; k < seq.size(); k++)
            send_byte(seq[k], end_stream && (k == seq.size() - 1));
    endtask

    task automatic test_plain_bytes();
        send_bytes('{8'h00, 8'h7F, 8'hFF, 8'h41}, 1'b0);
    endtask

    task automatic test_kana();
        send_bytes('{8'h1B, 8'h28, 8'h49, 8'h21, 8'h5F, 8'h60, 8'hA5}, 1'b0);
    endtask

    task automatic test_kanji_pairs();
        // extremes, a broken pair, then an escape that drops a waiting lead
        send_bytes('{8'h1B, 8'h24, 8'h42, 8'h21, 8'h21, 8'h7E, 8'h7E, 8'h30, 8'h0A,
                     8'h30, 8'h1B, 8'h28, 8'h42}, 1'b0);
    endtask

    task automatic test_escape_mismatch();
        send_bytes('{8'h1B, 8'h24, 8'h28, 8'h58, 8'h1B, 8'h1B, 8'h28, 8'h4A}, 1'b0);
    endtask

    task automatic test_stream_end();
        send_bytes('{8'h1B, 8'h24, 8'h40, 8'h30}, 1'b1);
        send_bytes('{8'h41, 8'h1B, 8'h24}, 1'b1);
    endtask

    task automatic send_random_stream();
        logic [7:0] s_bytes [$];
        int         sel;
        int         kind;
        int         cut;
        t_jis_mode  m;
        repeat ($urandom_range(1, 3)) begin
            sel  = $urandom_range(0, NUM_SEQ - 1);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                cut = $urandom_range(1, ESC_LEN[sel] - 1);
                for (int k = 0; k < cut; k++) s_bytes.push_back(ESC_SEQ[sel][k]);
                s_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (kind == 1) begin
                repeat ($urandom_range(1, 3)) s_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                m = ESC_MODE[sel];
                for (int k = 0; k < ESC_LEN[sel]; k++) s_bytes.push_back(ESC_SEQ[sel][k]);
                repeat ($urandom_range(1, 4)) begin
                    if (m >= MODE_KANJI_1978) begin
                        s_bytes.push_back(8'($urandom_range(PAIR_LO, PAIR_HI)));
                        if ($urandom_range(0, 7) != 0)
                            s_bytes.push_back(8'($urandom_range(PAIR_LO, PAIR_HI)));
                    end else if (m == MODE_KANA) begin
                        s_bytes.push_back(8'($urandom_range(PAIR_LO, KANA_HI)));
                    end else begin
                        s_bytes.push_back(8'($urandom_range(0, ASCII_HI)));
                    end
                end
            end
        end
        // end the stream inside an escape now and then
        if ($urandom_range(0, 4) == 0) begin
            sel = $urandom_range(0, NUM_SEQ - 1);
            cut = $urandom_range(1, ESC_LEN[sel] - 1);
            for (int k = 0; k < cut; k++) s_bytes.push_back(ESC_SEQ[sel][k]);
        end
        send_bytes(s_bytes, 1'b1);
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct, input int n_bytes);
        int stop_at;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        stop_at = sent_bytes + n_bytes;
        while (sent_bytes < stop_at) send_random_stream();
    endtask

    initial begin
        in_if.valid       = 1'b0;
        in_if.in_byte     = 8'h00;
        in_if.stream_last = 1'b0;
        out_if.ready      = 1'b0;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        sent_bytes        = 0;
        mismatch_count    = 0;
        jis_reset();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_bytes();
        test_kana();
        test_kanji_pairs();
        test_escape_mismatch();
        test_stream_end();
        test_random_phase(0, 0, 36);
        test_random_phase(69, 0, 36);
        test_random_phase(0, 69, 36);
        test_random_phase(18, 18, 36);

        in_if.valid = 1'b0;
        while (shift_jis_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
